// ===== rtl/kda_pkg.sv =====
// Package for the key debounce / auto-repeat block.
// Shared widths, codes and the configuration struct. No dependencies.
package kda_pkg;

  localparam int unsigned NumKeys = 4;
  localparam int unsigned PinW    = 4;   // fixed width of key_pins / key_events
  localparam int unsigned CntW    = 8;   // hold counter and its registers
  localparam int unsigned CfgDW   = 8;   // widest configuration register
  localparam int unsigned CfgIdxW = 1;

  localparam logic [NumKeys-1:0] KeyMask     = '1;
  localparam logic [CntW-1:0]    HoldTimeRst = 8'd50;
  localparam logic [CntW-1:0]    RepStepRst  = 8'd10;

  typedef enum logic {
    ModeScan = 1'b0,
    ModePoll = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHoldTime   = 1'b0,
    CfgRepeatStep = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CntW-1:0] hold_time;
    logic [CntW-1:0] repeat_step;
  } kda_cfg_t;

endpackage

// ===== rtl/kda_in_if.sv =====
// Input channel interface: valid/ready plus one scan or poll item.
// Depends on kda_pkg for the pin width.
interface kda_in_if;
  import kda_pkg::*;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [PinW-1:0] key_pins;

  modport source (output valid, output mode, output key_pins, input ready);
  modport sink   (input valid, input mode, input key_pins, output ready);
endinterface

// ===== rtl/kda_out_if.sv =====
// Output channel interface: valid/ready plus one key event word.
// Depends on kda_pkg for the pin width.
interface kda_out_if;
  import kda_pkg::*;
  logic            valid;
  logic            ready;
  logic [PinW-1:0] key_events;

  modport source (output valid, output key_events, input ready);
  modport sink   (input valid, input key_events, output ready);
endinterface

// ===== rtl/kda_regs.sv =====
// Configuration registers: hold time and repeat step.
// Depends on kda_pkg.
module kda_regs import kda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDW-1:0]   cfg_wdata_i,
  output kda_cfg_t           cfg_o
);

  kda_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgHoldTime:   cfg_d.hold_time   = cfg_wdata_i[CntW-1:0];
        CfgRepeatStep: cfg_d.repeat_step = cfg_wdata_i[CntW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time   <= HoldTimeRst;
      cfg_q.repeat_step <= RepStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/kda_qual.sv =====
// Key qualifier state: debounce sample pair, fresh flag, arm/repeat masks
// and hold counter. One item per step_i. Depends on kda_pkg.
module kda_qual import kda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               mode_i,
  input  logic [PinW-1:0]    key_pins_i,
  input  kda_cfg_t           cfg_i,
  output logic [PinW-1:0]    key_events_o
);

  logic [NumKeys-1:0] prev_q, prev_d;
  logic [NumKeys-1:0] stable_q, stable_d;
  logic               fresh_q, fresh_d;
  logic [NumKeys-1:0] armed_q, armed_d;
  logic [NumKeys-1:0] rep_q, rep_d;
  logic [CntW-1:0]    hold_q, hold_d;

  logic [NumKeys-1:0] sample, armed_rel, rep_rel, rep_sel, events;
  logic [CntW-1:0]    hold_base;
  logic               new_press;

  always_comb begin
    sample    = ~key_pins_i[NumKeys-1:0];
    // released keys re-arm
    armed_rel = armed_q | ~stable_q;
    rep_rel   = rep_q | ~stable_q;
    new_press = |(armed_rel & stable_q);
    hold_base = new_press ? '0 : hold_q;
    rep_sel   = new_press ? armed_rel : rep_rel;

    prev_d   = prev_q;
    stable_d = stable_q;
    fresh_d  = fresh_q;
    armed_d  = armed_q;
    rep_d    = rep_q;
    hold_d   = hold_q;
    events   = '0;

    if (step_i) begin
      if (mode_i == ModeScan) begin
        stable_d = sample & prev_q;
        prev_d   = sample;
        fresh_d  = 1'b1;
      end else if (fresh_q) begin
        stable_d = '0;
        fresh_d  = 1'b0;
        rep_d    = rep_sel;
        if (hold_base >= cfg_i.hold_time) begin
          events = stable_q & rep_sel;
          hold_d = hold_base - cfg_i.repeat_step;   // wraps mod 256
        end else begin
          events = stable_q & armed_rel;
          hold_d = hold_base + 1'b1;
        end
        armed_d = armed_rel & ~events;
      end
    end
  end

  always_comb begin
    key_events_o = '0;
    key_events_o[NumKeys-1:0] = events;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      fresh_q  <= 1'b0;
      armed_q  <= KeyMask;
      rep_q    <= KeyMask;
      hold_q   <= '0;
    end else begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      fresh_q  <= fresh_d;
      armed_q  <= armed_d;
      rep_q    <= rep_d;
      hold_q   <= hold_d;
    end
  end

  // A poll on a stale scan reports nothing.
  a_stale_poll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == ModePoll && !fresh_q |-> events == '0)
    else $error("stale poll produced events");

  // Any poll leaves the scan consumed.
  a_poll_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == ModePoll |=> !fresh_q && stable_q == '0)
    else $error("poll did not consume scan");

  // A reported key is disarmed right after.
  a_event_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && events != '0 |=> (armed_q & $past(events)) == '0)
    else $error("reported key still armed");

endmodule

// ===== rtl/key_debounce_autorepeat.sv =====
// Top level of the four-key debounce / auto-repeat qualifier.
// Depends on kda_pkg, kda_in_if, kda_out_if, kda_regs and kda_qual.
//
// Usage:
//   in_i carries one beat per scan tick (mode 0, raw active-low pins) or
//   poll (mode 1). Scan beats return nothing; every poll beat returns one
//   beat on out_o whose key_events marks new presses and auto-repeats.
//   The cfg port writes hold_time (index 0) and repeat_step (index 1);
//   write only while the block is idle.
// Flow: an accepted beat waits in the input register until it advances; a
//   poll's result is then captured in the output register and offered on out_o.
// Throughput: one beat per cycle when out_o is not stalling polls, set by
//   the input register feeding the qualifier logic and the single output
//   register; one 8-bit compare and one 8-bit add/subtract sit between them.
// Stall: when out_o holds a result not yet taken, a poll sitting in the
//   input register waits and in_i.ready drops; a scan beat still passes
//   since it yields no result. A result already offered stays put.
// Reset: masks rearm, sample/stable/fresh/counter clear, hold_time = 50,
//   repeat_step = 10; both channels come up empty.
module key_debounce_autorepeat import kda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  kda_in_if.sink             in_i,
  kda_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDW-1:0]   cfg_wdata_i
);

  kda_cfg_t cfg;

  // input register
  logic            in_vld_q, in_vld_d;
  logic            in_mode_q;
  logic [PinW-1:0] in_pins_q;
  logic            advance;

  // result register
  logic            out_vld_q, out_vld_d;
  logic [PinW-1:0] out_ev_q;
  logic [PinW-1:0] events;

  kda_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kda_qual u_qual (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .mode_i       (in_mode_q),
    .key_pins_i   (in_pins_q),
    .cfg_i        (cfg),
    .key_events_o (events)
  );

  // Scans never need the result slot; polls need it free or draining.
  assign advance    = in_vld_q &&
                      (in_mode_q == ModeScan || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && in_mode_q == ModePoll) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q <= in_i.mode;
      in_pins_q <= in_i.key_pins;
    end
    if (advance && in_mode_q == ModePoll) begin
      out_ev_q <= events;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.key_events = out_ev_q;

  // A poll only moves on when the result slot can take it.
  a_poll_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_mode_q == ModePoll |-> !out_vld_q || out_o.ready)
    else $error("poll advanced into an occupied result slot");

  // An empty input register always accepts.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_i.ready)
    else $error("input stalled while empty");

  // A scan creates no result beat.
  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_mode_q == ModeScan && (!out_vld_q || out_o.ready) |=> !out_vld_q)
    else $error("scan produced a result");

endmodule

// ===== bench/key_debounce_autorepeat_tb.sv =====
// Testbench for key_debounce_autorepeat: random and directed scan/poll beats,
// with a built-in predictor of the debounce / auto-repeat behavior.
// Depends on kda_pkg, kda_in_if, kda_out_if and the RTL top level.
module key_debounce_autorepeat_tb;
  import kda_pkg::*;

  localparam int unsigned IdleLimit   = 1000;  // cycles without any beat moving
  localparam int unsigned SettleTicks = 4;     // block latency plus margin

  typedef struct packed {
    mode_e             mode;
    logic [PinW-1:0]   pins;
  } kda_beat_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDW-1:0]   cfg_wdata;

  kda_in_if  in_bus ();
  kda_out_if out_bus ();

  key_debounce_autorepeat u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Stimulus and expectation stores
  kda_beat_t       pending_beats[$];
  logic [PinW-1:0] expected_events[$];

  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  logic        in_taken    = 1'b0;  // input beat moved at the last rising edge
  logic        quiet       = 1'b0;  // nothing queued, offered or owed

  // Predictor state: a private copy of the block's registers
  logic [CntW-1:0]    hold_time_q;
  logic [CntW-1:0]    repeat_step_q;
  logic [NumKeys-1:0] last_sample;
  logic [NumKeys-1:0] debounced;
  logic               scan_fresh;
  logic [NumKeys-1:0] press_armed;
  logic [NumKeys-1:0] repeat_armed;
  logic [CntW-1:0]    hold_cnt;

  // Sender / receiver pacing
  int unsigned        burst_left = 1;
  int unsigned        gap_left   = 0;
  logic [15:0]        ready_pattern = '1;
  int unsigned        pattern_left  = 0;

  // Advance the debounce / repeat state by one beat. Returns 1 when the
  // beat yields a result, with the reported keys in events.
  function automatic bit qualify_beat(input mode_e mode, input logic [PinW-1:0] pins,
                                      output logic [PinW-1:0] events);
    logic [NumKeys-1:0] sample;
    logic [NumKeys-1:0] keys;
    events = '0;
    if (mode == ModeScan) begin
      // Active-low pins; a key counts only if seen on two scans in a row.
      sample      = ~pins[NumKeys-1:0];
      debounced   = sample & last_sample;
      scan_fresh  = 1'b1;
      last_sample = sample;
      return 1'b0;
    end
    // Poll with nothing new: zero result, state untouched.
    if (!scan_fresh) return 1'b1;
    keys       = debounced;
    debounced  = '0;
    scan_fresh = 1'b0;
    // Released keys rearm.
    press_armed  = press_armed | ~keys;
    repeat_armed = repeat_armed | ~keys;
    // Fresh press restarts the hold timer.
    if ((press_armed & keys) != '0) begin
      hold_cnt     = '0;
      repeat_armed = press_armed;
    end
    if (hold_cnt >= hold_time_q) begin
      keys     = keys & repeat_armed;
      hold_cnt = hold_cnt - repeat_step_q;  // wraps mod 256
    end else begin
      keys     = keys & press_armed;
      hold_cnt = hold_cnt + 1'b1;
    end
    press_armed = press_armed & ~keys;
    events      = PinW'(keys);
    return 1'b1;
  endfunction

  // Clock, plus known levels on every input from time zero
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgHoldTime;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = ModeScan;
    in_bus.key_pins = '1;
    out_bus.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts of beats separated by random gaps; some bursts run long
  // with no gap at all. A beat stays put until it is taken.
  always @(negedge clk_i) begin : sender
    kda_beat_t beat;
    logic      next_valid;
    next_valid = 1'b0;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (in_bus.valid && !in_taken) begin
      next_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_beats.size() > 0) begin
      beat = pending_beats.pop_front();
      in_bus.mode     <= beat.mode;
      in_bus.key_pins <= beat.pins;
      next_valid = 1'b1;
      if (burst_left <= 1) begin
        if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(30, 80);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 7);
        end
      end else begin
        burst_left--;
      end
    end
    in_bus.valid <= next_valid;
  end

  // Receiver: a rotating stall mask, redrawn when its countdown runs out; about a
  // quarter of the time the mask is solid and there is no back-pressure.
  always @(negedge clk_i) begin : receiver
    if (pattern_left == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
      pattern_left  = 63;
    end else begin
      pattern_left--;
    end
    out_bus.ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Monitor: predict on every accepted input beat, check every accepted
  // result beat against the oldest prediction, and watch for a hang.
  always @(posedge clk_i) begin : monitor
    logic [PinW-1:0] events;
    logic [PinW-1:0] want;
    logic            in_fire;
    logic            out_fire;
    in_fire  = rst_ni && in_bus.valid && in_bus.ready;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;
    if (in_fire) begin
      if (qualify_beat(mode_e'(in_bus.mode), in_bus.key_pins, events))
        expected_events.push_back(events);
    end
    if (out_fire) begin
      if (expected_events.size() == 0) begin
        $error("key_events beat with no prediction pending: actual %h", out_bus.key_events);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_bus.key_events !== want) begin
          $error("key_events mismatch: expected %h, actual %h", want, out_bus.key_events);
          fail_count++;
        end
      end
    end
    in_taken <= in_fire;
    quiet    <= (pending_beats.size() == 0) && !(in_bus.valid && !in_fire) &&
                (expected_events.size() == 0);
    if (in_fire || out_fire) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_beat(input mode_e mode, input logic [PinW-1:0] pins);
    kda_beat_t beat;
    beat.mode = mode;
    beat.pins = pins;
    pending_beats.push_back(beat);
  endtask

  // Hold one key set for a number of scan/poll pairs, with the odd bounce,
  // doubled scan or doubled poll mixed in. Returns the beats queued.
  task automatic push_hold(input logic [PinW-1:0] pins, input int unsigned pairs,
                           output int unsigned queued);
    queued = 0;
    for (int unsigned p = 0; p < pairs; p++) begin
      if ($urandom_range(0, 9) == 0)
        push_beat(ModeScan, pins ^ PinW'(1 << $urandom_range(0, PinW - 1)));
      else
        push_beat(ModeScan, pins);
      queued++;
      if ($urandom_range(0, 11) == 0) begin
        push_beat(ModeScan, pins);
        queued++;
      end
      push_beat(ModePoll, PinW'($urandom()));
      queued++;
      if ($urandom_range(0, 11) == 0) begin
        push_beat(ModePoll, PinW'($urandom()));
        queued++;
      end
    end
  endtask

  // Random traffic: mostly held-key sessions, some loose noise beats.
  task automatic push_random(input int unsigned n_beats);
    int unsigned        done;
    int unsigned        queued;
    int unsigned        pairs;
    logic [NumKeys-1:0] pressed;
    done = 0;
    while (done < n_beats) begin
      if ($urandom_range(0, 99) < 15) begin
        push_beat(mode_e'($urandom_range(0, 1)), PinW'($urandom()));
        done++;
      end else begin
        pressed = NumKeys'($urandom_range(0, 15));
        pairs   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 25);
        push_hold(PinW'(~pressed), pairs, queued);
        done += queued;
      end
    end
  endtask

  // Wait until the block has nothing in flight, then let it settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (!quiet) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  // Write both registers back to back; the predictor follows at once since
  // no beat can move while the block is drained.
  task automatic set_timing(input logic [CntW-1:0] hold, input logic [CntW-1:0] step);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgHoldTime;
    cfg_wdata <= CfgDW'(hold);
    hold_time_q = hold;
    @(negedge clk_i);
    cfg_idx   <= CfgRepeatStep;
    cfg_wdata <= CfgDW'(step);
    repeat_step_q = step;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned     queued;
    logic [CntW-1:0] hold_set [9];
    logic [CntW-1:0] step_set [9];

    // Register settings per phase; the last one is drawn at random.
    hold_set = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0,   8'd5, 8'd2, 8'd12, 8'd0};
    step_set = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd2, 8'd0, 8'd3, 8'd0};
    hold_set[8] = CntW'($urandom_range(0, 20));
    step_set[8] = CntW'($urandom());

    hold_time_q   = HoldTimeRst;
    repeat_step_q = RepStepRst;
    last_sample   = '0;
    debounced     = '0;
    scan_fresh    = 1'b0;
    press_armed   = KeyMask;
    repeat_armed  = KeyMask;
    hold_cnt      = '0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings
    push_beat(ModePoll, 4'hF);  // poll before any scan: zero result
    push_beat(ModeScan, 4'hF);  // scan alone gives nothing
    push_beat(ModePoll, 4'h0);  // fresh scan, nothing pressed
    push_beat(ModeScan, 4'h0);  // first sight of all keys: not yet stable
    push_beat(ModeScan, 4'h0);  // now stable
    push_beat(ModePoll, 4'h0);  // new press on all four keys
    push_beat(ModePoll, 4'hF);  // no fresh scan in between
    push_beat(ModeScan, 4'h0);
    push_beat(ModePoll, 4'h0);  // still held, far from the repeat point
    push_beat(ModeScan, 4'hA);  // half the keys released
    push_beat(ModePoll, 4'h5);
    push_beat(ModeScan, 4'h5);  // the other half pressed
    push_beat(ModeScan, 4'h5);
    push_beat(ModePoll, 4'hA);
    push_beat(ModeScan, 4'hE);
    push_beat(ModeScan, 4'hE);
    push_beat(ModePoll, 4'h1);
    push_beat(ModeScan, 4'hF);
    push_beat(ModeScan, 4'hF);
    push_beat(ModePoll, 4'hE);  // everything released
    push_beat(ModeScan, 4'h7);
    push_beat(ModeScan, 4'h7);
    push_beat(ModePoll, 4'h8);
    push_beat(ModePoll, 4'h0);
    push_random(100);

    for (int i = 0; i < 9; i++) begin
      // Sender holds off here until every owed result has come back.
      wait_drained();
      set_timing(hold_set[i], step_set[i]);
      if (hold_set[i] == 8'd255) begin
        // Release everything, then hold past the longest repeat delay so
        // the counter climbs to its top and the repeat step takes it back to zero.
        push_beat(ModeScan, 4'hF);
        push_beat(ModeScan, 4'hF);
        push_beat(ModePoll, 4'hF);
        for (int p = 0; p < 265; p++) begin
          push_beat(ModeScan, 4'h9);
          push_beat(ModePoll, PinW'($urandom()));
        end
        push_random(40);
      end else begin
        push_random(65);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
